// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: transaction
// payloads, operation and error codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	// occupancy must reach DEPTH_DEF itself
	localparam int OCC_W     = $clog2(DEPTH_DEF + 1);

	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_REAR  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_UNDERFLOW = 2'd1,
		ERR_OVERFLOW  = 2'd2
	} err_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [DATA_W-1:0]  value;
	} op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  front_value;
		logic signed [DATA_W-1:0]  rear_value;
		logic [OCC_W-1:0]          occupancy;
		err_t                      error;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_RESP = 2'd2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // take the input transaction, update pointers, write slot
		logic load;     // load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free; // result register can take a new result this cycle
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output      logic [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ===== sv/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer of the queue: accepts a transaction, steps the slot read and
// loads the result register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	output      logic          op_stall,
	input  wire deq_pkg::sts_t sts,
	output      deq_pkg::cmd_t cmd
);

	deq_pkg::state_t state_q;
	deq_pkg::state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			deq_pkg::ST_IDLE: begin
				if (op_valid) begin
					state_d = deq_pkg::ST_READ;
				end
			end
			deq_pkg::ST_READ: begin
				state_d = deq_pkg::ST_RESP;
			end
			deq_pkg::ST_RESP: begin
				if (sts.out_free) begin
					state_d = deq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = deq_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		op_stall = 1'b1;
		case (state_q)
			deq_pkg::ST_IDLE: begin
				op_stall   = 1'b0;
				cmd.accept = op_valid;
			end
			deq_pkg::ST_READ: begin
				// slot read in flight, hold the input
				op_stall = 1'b1;
			end
			deq_pkg::ST_RESP: begin
				cmd.load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// an accepted transaction always moves on to the slot read
	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == deq_pkg::ST_READ)
		else $error("accepted transaction did not advance to read");

	// a result is never loaded over one that is still waiting
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.out_free)
		else $error("result loaded while result register busy");

endmodule

`default_nettype wire

// ===== sv/deq_dp.sv =====
// ----------------------------------------------------------------------------
// deq_dp
// Datapath of the queue: head index and count registers, ring address
// arithmetic, slot RAM and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire deq_pkg::cmd_t cmd,
	output      deq_pkg::sts_t sts,
	input  wire deq_pkg::op_t  op,
	output      logic          res_valid,
	input  wire logic          res_stall,
	output      deq_pkg::res_t res
);

	localparam int DEPTH = deq_pkg::DEPTH_DEF;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [SW-1:0] WRAP_SUM = SW'(DEPTH);

	logic [PW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	deq_pkg::err_t      err_q;
	logic               out_valid_q;
	deq_pkg::res_t      res_q;

	logic [PW-1:0]      head_d;
	logic [CW-1:0]      count_d;
	deq_pkg::err_t      err_d;
	logic               wr;
	logic [PW-1:0]      waddr;
	logic [PW-1:0]      head_inc;
	logic [PW-1:0]      head_dec;
	logic [SW-1:0]      tail_sum;
	logic [SW-1:0]      rear_sum;
	logic [PW-1:0]      tail_idx;
	logic [PW-1:0]      rear_idx;
	logic               full;
	logic               empty;
	logic [deq_pkg::DATA_W-1:0] rdata_front;
	logic [deq_pkg::DATA_W-1:0] rdata_rear;

	// ring index arithmetic
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + PW'(1);
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - PW'(1);
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign rear_sum = tail_sum - SW'(1);
	assign tail_idx = (tail_sum >= WRAP_SUM) ? PW'(tail_sum - WRAP_SUM) : PW'(tail_sum);
	assign rear_idx = (rear_sum >= WRAP_SUM) ? PW'(rear_sum - WRAP_SUM) : PW'(rear_sum);
	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);

	// decode the operation
	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		err_d   = deq_pkg::ERR_OK;
		wr      = 1'b0;
		waddr   = tail_idx;
		case (op.kind)
			deq_pkg::KIND_PUSH_FRONT: begin
				if (full) begin
					err_d = deq_pkg::ERR_OVERFLOW;
				end else begin
					head_d  = head_dec;
					waddr   = head_dec;
					wr      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::KIND_PUSH_REAR: begin
				if (full) begin
					err_d = deq_pkg::ERR_OVERFLOW;
				end else begin
					wr      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			deq_pkg::KIND_POP_FRONT: begin
				if (empty) begin
					err_d = deq_pkg::ERR_UNDERFLOW;
				end else begin
					head_d  = head_inc;
					count_d = count_q - CW'(1);
				end
			end
			deq_pkg::KIND_POP_REAR: begin
				if (empty) begin
					err_d = deq_pkg::ERR_UNDERFLOW;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				err_d = deq_pkg::ERR_OK;
			end
		endcase
	end

	// pointer and error registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			err_q   <= deq_pkg::ERR_OK;
		end else if (cmd.accept) begin
			head_q  <= head_d;
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

	// slot store
	deq_ram #(
		.WIDTH(deq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.accept & wr),
		.waddr   (waddr),
		.wdata   (op.value),
		.raddr_a (head_q),
		.rdata_a (rdata_front),
		.raddr_b (rear_idx),
		.rdata_b (rdata_rear)
	);

	// result valid: set on load, drop when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload; an empty queue reads as zero
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.front_value <= empty ? '0 : rdata_front;
			res_q.rear_value  <= empty ? '0 : rdata_rear;
			res_q.occupancy   <= deq_pkg::OCC_W'(count_q);
			res_q.error       <= err_q;
		end
	end

	assign sts.out_free = !out_valid_q || !res_stall;
	assign res_valid    = out_valid_q;
	assign res          = res_q;

	// count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("stored count exceeds capacity");

	// a rear push that fits grows the count by one
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && op.kind == deq_pkg::KIND_PUSH_REAR && !full)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("rear push did not grow count");

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
// Each op transaction pushes at the front or rear, or pops from the front or
// rear, and yields one res transaction carrying the front and rear values
// after the operation (zero when empty), the occupancy and an error code
// (underflow on pop of an empty queue, overflow on push into a full one; the
// queue is unchanged in both cases). Each transaction steps through the
// controller states in order: in IDLE it is accepted, head and count are
// updated and the slot written; READ reads front and rear from the
// two-read-port slot RAM; RESP loads the result register once it is free.
// A new transaction may be accepted while the previous result still waits.
// The slot store needs no clearing after reset. The capacity is the package
// constant DEPTH_DEF, and the occupancy field is sized to hold it.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_valid,
	output      logic          op_stall,
	input  wire deq_pkg::op_t  op,
	output      logic          res_valid,
	input  wire logic          res_stall,
	output      deq_pkg::res_t res
);

	deq_pkg::cmd_t cmd;
	deq_pkg::sts_t sts;

	// sequencer
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_stall (op_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	deq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.op        (op),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire
